// ----- hw/rtl/afr_pkg.sv -----
`timescale 1ns / 1ps

package afr_pkg;

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 7;
  localparam int REG_IDX_W = 3;
  localparam int NUM_REGS  = 5;

  // input command codes
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_IDLE = 1'b1;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_OWN       = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MOTOR     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BROADCAST = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_REMOTE    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PANEL     = 3'd4;

  typedef enum logic [2:0] {
    PH_NONE  = 3'd0,
    PH_HDR0  = 3'd1,
    PH_HDR1  = 3'd2,
    PH_HDR2  = 3'd3,
    PH_HDR3  = 3'd4,
    PH_COUNT = 3'd5,
    PH_DATA  = 3'd6,
    PH_CSUM  = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    DR_IDLE,
    DR_READ,
    DR_HOLD
  } drain_state_t;

  typedef struct packed {
    logic             valid;
    logic [LEN_W-1:0] length;
  } frame_done_t;

endpackage

// ----- hw/rtl/afr_frame_store.sv -----
`timescale 1ns / 1ps

module afr_frame_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [afr_pkg::BYTE_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [afr_pkg::BYTE_W-1:0] rdata
);

  logic [afr_pkg::BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/afr_frame_parser.sv -----
`timescale 1ns / 1ps

module afr_frame_parser #(
  parameter int FRAME_CAPACITY = 64,
  parameter int DATA_LIMIT     = 32,
  parameter int AW             = 6,
  parameter int CW             = 7
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [afr_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [afr_pkg::BYTE_W-1:0]    cfg_data,
  input  logic                          accept,
  input  logic                          command,
  input  logic [afr_pkg::BYTE_W-1:0]    rx_byte,
  output logic                          we,
  output logic [AW-1:0]                 waddr,
  output logic [afr_pkg::BYTE_W-1:0]    wdata,
  output afr_pkg::frame_done_t          done
);

  logic [afr_pkg::BYTE_W-1:0] addr_id [afr_pkg::NUM_REGS];

  logic                       line_idle, line_idle_next;
  afr_pkg::phase_t            phase, phase_next;
  logic [CW-1:0]              stored_count, stored_count_next;
  logic [afr_pkg::BYTE_W-1:0] running_sum, running_sum_next;
  logic [5:0]                 data_target, data_target_next;
  logic [5:0]                 data_seen, data_seen_next;

  logic                       id_match;
  logic                       active;
  afr_pkg::phase_t            eff_phase;
  logic [CW-1:0]              eff_count;
  logic [CW-1:0]              count_inc;
  logic [5:0]                 seen_inc;
  logic [afr_pkg::BYTE_W-1:0] sum_add;
  logic                       do_store;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < afr_pkg::NUM_REGS; k++) addr_id[k] <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        afr_pkg::REG_OWN:       addr_id[0] <= cfg_data;
        afr_pkg::REG_MOTOR:     addr_id[1] <= cfg_data;
        afr_pkg::REG_BROADCAST: addr_id[2] <= cfg_data;
        afr_pkg::REG_REMOTE:    addr_id[3] <= cfg_data;
        afr_pkg::REG_PANEL:     addr_id[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    id_match = 1'b0;
    for (int k = 0; k < afr_pkg::NUM_REGS; k++) begin
      if (addr_id[k] == rx_byte) id_match = 1'b1;
    end
  end

  // a byte counts when the line is busy, or when idle and it names a start ID
  assign active    = accept && (command == afr_pkg::CMD_BYTE) && (!line_idle || id_match);
  assign eff_phase = line_idle ? afr_pkg::PH_HDR0 : phase;
  assign eff_count = line_idle ? '0 : stored_count;
  assign count_inc = eff_count + CW'(1);
  assign seen_inc  = data_seen + 6'd1;
  assign sum_add   = running_sum + rx_byte;

  // next state
  always_comb begin
    line_idle_next    = line_idle;
    phase_next        = phase;
    stored_count_next = stored_count;
    running_sum_next  = running_sum;
    data_target_next  = data_target;
    data_seen_next    = data_seen;
    do_store          = 1'b0;
    if (accept && command == afr_pkg::CMD_IDLE) begin
      line_idle_next = 1'b1;
    end else if (active) begin
      line_idle_next    = 1'b0;
      stored_count_next = eff_count;
      if (eff_count >= CW'(FRAME_CAPACITY)) begin
        phase_next = afr_pkg::PH_NONE;
      end else begin
        unique case (eff_phase) inside
          afr_pkg::PH_HDR0: begin
            running_sum_next = rx_byte;
            do_store         = 1'b1;
            phase_next       = afr_pkg::PH_HDR1;
          end
          afr_pkg::PH_HDR1, afr_pkg::PH_HDR2, afr_pkg::PH_HDR3: begin
            running_sum_next = sum_add;
            do_store         = 1'b1;
            phase_next       = afr_pkg::phase_t'(eff_phase + 3'd1);
          end
          afr_pkg::PH_COUNT: begin
            if (rx_byte >= afr_pkg::BYTE_W'(DATA_LIMIT)) begin
              phase_next = afr_pkg::PH_NONE;
            end else begin
              data_target_next = rx_byte[5:0];
              data_seen_next   = '0;
              running_sum_next = sum_add;
              do_store         = 1'b1;
              phase_next       = (rx_byte != '0) ? afr_pkg::PH_DATA : afr_pkg::PH_CSUM;
            end
          end
          afr_pkg::PH_DATA: begin
            data_seen_next = seen_inc;
            if (seen_inc >= 6'(DATA_LIMIT)) begin
              phase_next = afr_pkg::PH_NONE;
            end else begin
              running_sum_next = sum_add;
              do_store         = 1'b1;
              if (seen_inc >= data_target) phase_next = afr_pkg::PH_CSUM;
            end
          end
          afr_pkg::PH_CSUM: begin
            running_sum_next = sum_add;
            do_store         = 1'b1;
            if (sum_add == '0) data_seen_next = '0;
            phase_next     = afr_pkg::PH_NONE;
            line_idle_next = 1'b1;
          end
          afr_pkg::PH_NONE: ;
          default: ;
        endcase
      end
      if (do_store) stored_count_next = count_inc;
    end
  end

  // outputs
  always_comb begin
    we          = do_store;
    waddr       = eff_count[AW-1:0];
    wdata       = rx_byte;
    done.valid  = active && (eff_count < CW'(FRAME_CAPACITY)) &&
                  (eff_phase == afr_pkg::PH_CSUM) && (sum_add == '0);
    done.length = afr_pkg::LEN_W'(count_inc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_idle    <= 1'b1;
      phase        <= afr_pkg::PH_NONE;
      stored_count <= '0;
      running_sum  <= '0;
      data_target  <= '0;
      data_seen    <= '0;
    end else begin
      line_idle    <= line_idle_next;
      phase        <= phase_next;
      stored_count <= stored_count_next;
      running_sum  <= running_sum_next;
      data_target  <= data_target_next;
      data_seen    <= data_seen_next;
    end
  end

endmodule

// ----- hw/rtl/afr_drain.sv -----
`timescale 1ns / 1ps

module afr_drain #(
  parameter int AW = 6
) (
  input  logic                        clk,
  input  logic                        rst,
  input  afr_pkg::frame_done_t        done,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic                        last,
  output logic [afr_pkg::LEN_W-1:0]   frame_length,
  output logic                        busy,
  output logic                        re,
  output logic [AW-1:0]               raddr
);

  afr_pkg::drain_state_t      state, state_next;
  logic [afr_pkg::LEN_W-1:0]  idx, idx_next;
  logic [afr_pkg::LEN_W-1:0]  length, length_next;

  assign last         = (idx + afr_pkg::LEN_W'(1)) == length;
  assign frame_length = length;
  assign raddr        = idx[AW-1:0];

  // next state
  always_comb begin
    state_next  = state;
    idx_next    = idx;
    length_next = length;
    unique case (state)
      afr_pkg::DR_IDLE: begin
        if (done.valid) begin
          idx_next    = '0;
          length_next = done.length;
          state_next  = afr_pkg::DR_READ;
        end
      end
      afr_pkg::DR_READ: state_next = afr_pkg::DR_HOLD;
      afr_pkg::DR_HOLD: begin
        if (out_ready) begin
          if (last) begin
            state_next = afr_pkg::DR_IDLE;
          end else begin
            idx_next   = idx + afr_pkg::LEN_W'(1);
            state_next = afr_pkg::DR_READ;
          end
        end
      end
      default: state_next = afr_pkg::DR_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    re        = (state == afr_pkg::DR_READ);
    out_valid = (state == afr_pkg::DR_HOLD);
    busy      = (state != afr_pkg::DR_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= afr_pkg::DR_IDLE;
      idx    <= '0;
      length <= '0;
    end else begin
      state  <= state_next;
      idx    <= idx_next;
      length <= length_next;
    end
  end

endmodule

// ----- hw/rtl/addressed_frame_receiver_unit.sv -----
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// -------   ---------------------  ---------------------------------------
// input     in_valid / in_ready    command, rx_byte
// output    out_valid / out_ready  frame_byte, frame_length, last
// config    cfg_write              cfg_index, cfg_data (no handshake back)
//
// An input item is taken whenever no frame is draining.
// A good frame drains from the frame store byte by byte: each byte is
// read from the store, then held in the output register until out_ready
// is high; in_ready is low throughout the drain.
// Reset (rst, synchronous) clears control state and address registers;
// the frame store needs no clearing pass, as each emitted byte is written
// in the same frame before it is read.

module addressed_frame_receiver_unit #(
  parameter int FRAME_CAPACITY = 64,
  parameter int DATA_LIMIT     = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [afr_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [afr_pkg::BYTE_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          command,
  input  logic [afr_pkg::BYTE_W-1:0]    rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [afr_pkg::BYTE_W-1:0]    frame_byte,
  output logic [afr_pkg::LEN_W-1:0]     frame_length,
  output logic                          last
);

  // store address width and a count wide enough to reach the capacity
  localparam int AW = (FRAME_CAPACITY > 1) ? $clog2(FRAME_CAPACITY) : 1;
  localparam int CW = $clog2(FRAME_CAPACITY + 1);

  logic                       accept;
  logic                       drain_busy;
  logic                       we;
  logic [AW-1:0]              waddr;
  logic [afr_pkg::BYTE_W-1:0] wdata;
  logic                       re;
  logic [AW-1:0]              raddr;
  afr_pkg::frame_done_t       done;

  // hold off new items while a frame drains
  assign in_ready = !drain_busy;
  assign accept   = in_valid && in_ready;

  afr_frame_parser #(
    .FRAME_CAPACITY(FRAME_CAPACITY),
    .DATA_LIMIT    (DATA_LIMIT),
    .AW            (AW),
    .CW            (CW)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .accept   (accept),
    .command  (command),
    .rx_byte  (rx_byte),
    .we       (we),
    .waddr    (waddr),
    .wdata    (wdata),
    .done     (done)
  );

  // frame bytes land here in arrival order; the drain reads them back
  afr_frame_store #(
    .DEPTH(FRAME_CAPACITY),
    .AW   (AW)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(frame_byte)
  );

  // the store's read register serves as the output data register
  afr_drain #(
    .AW(AW)
  ) u_drain (
    .clk         (clk),
    .rst         (rst),
    .done        (done),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .last        (last),
    .frame_length(frame_length),
    .busy        (drain_busy),
    .re          (re),
    .raddr       (raddr)
  );

endmodule

// ----- hw/rtl/afr_checker.sv -----
`timescale 1ns / 1ps

module afr_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [afr_pkg::BYTE_W-1:0]    frame_byte,
  input logic [afr_pkg::LEN_W-1:0]     frame_length,
  input logic                          last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_byte) &&
      $stable(frame_length) && $stable(last))
    else $error("stalled result changed");

  // a waiting item stays offered
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid)
    else $error("input item withdrawn before acceptance");

  // no item taken while a frame drains
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready during drain");

  // after the final byte the drain stops
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last |=> !out_valid && in_ready)
    else $error("drain continued past final byte");

  // within a frame the length holds between bytes
  a_len_steady: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> !out_valid && $stable(frame_length))
    else $error("frame length changed within frame");

endmodule

bind addressed_frame_receiver_unit afr_checker u_afr_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .frame_byte  (frame_byte),
  .frame_length(frame_length),
  .last        (last)
);

// ----- bench/tb_addressed_frame_receiver_unit.sv -----
`timescale 1ns / 1ps

// Bench for the addressed frame receiver. Serial bytes and idle events go in;
// the bytes of each good frame come back out. Every accepted item goes
// through a shadow framer kept here, and each byte of a good frame is queued
// for comparison with what leaves the block.
module tb_addressed_frame_receiver_unit;

  localparam int FRAME_CAPACITY = 64;
  localparam int DATA_LIMIT     = 32;
  localparam int IDLE_PCT       = 26;      // chance in a hundred of a gap cycle
  localparam int SETTLE_CYCLES  = 8;       // lets an unproductive item finish
  localparam int LIMIT_CYCLES   = 500000;

  typedef struct {
    logic [afr_pkg::BYTE_W-1:0] data;
    logic [afr_pkg::LEN_W-1:0]  length;
    logic                       last;
  } frame_out_t;

  logic                          clk;
  logic                          rst       = 1'b1;
  logic                          cfg_write = 1'b0;
  logic [afr_pkg::REG_IDX_W-1:0] cfg_index = afr_pkg::REG_OWN;
  logic [afr_pkg::BYTE_W-1:0]    cfg_data  = '0;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  logic                          command   = afr_pkg::CMD_IDLE;
  logic [afr_pkg::BYTE_W-1:0]    rx_byte   = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [afr_pkg::BYTE_W-1:0]    frame_byte;
  logic [afr_pkg::LEN_W-1:0]     frame_length;
  logic                          last;

  // Shadow framer state and its copy of the address registers.
  logic [afr_pkg::BYTE_W-1:0]    start_ids [afr_pkg::NUM_REGS];
  logic                          rx_idle   = 1'b1;
  afr_pkg::phase_t               rx_phase  = afr_pkg::PH_NONE;
  logic [afr_pkg::LEN_W-1:0]     rx_count  = '0;
  logic [afr_pkg::BYTE_W-1:0]    rx_sum    = '0;
  logic [5:0]                    rx_target = '0;
  logic [5:0]                    rx_seen   = '0;
  logic [afr_pkg::BYTE_W-1:0]    rx_store [FRAME_CAPACITY];

  frame_out_t           expected_bytes [$];
  int                   mismatches  = 0;
  int                   frame_items = 0;   // items sent as part of whole frames
  int                   cycles      = 0;
  bit                   steady      = 1'b0; // suppress all gaps and stalls

  addressed_frame_receiver_unit #(
    .FRAME_CAPACITY(FRAME_CAPACITY),
    .DATA_LIMIT    (DATA_LIMIT)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .frame_byte  (frame_byte),
    .frame_length(frame_length),
    .last        (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow framer
  // ---------------------------------------------------------------------------

  function automatic bit is_start_id(input logic [afr_pkg::BYTE_W-1:0] b);
    for (int k = 0; k < afr_pkg::NUM_REGS; k++)
      if (start_ids[k] == b) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void store_frame_byte(input logic [afr_pkg::BYTE_W-1:0] b);
    rx_store[rx_count[5:0]] = b;
    rx_count = rx_count + 1'b1;
  endfunction

  // Advance the shadow framer by one accepted item; queue the whole frame
  // when a checksum byte brings the running sum to zero.
  task automatic advance_framer(input logic cmd, input logic [afr_pkg::BYTE_W-1:0] b);
    int flen;
    if (cmd == afr_pkg::CMD_IDLE) begin
      rx_idle = 1'b1;
      return;
    end
    // While the line is idle only a start ID is of interest.
    if (rx_idle) begin
      if (!is_start_id(b)) return;
      rx_phase = afr_pkg::PH_HDR0;
      rx_count = '0;
    end
    rx_idle = 1'b0;
    // Store full: abort, the line stays busy until the next idle event.
    if (rx_count >= FRAME_CAPACITY) begin
      rx_phase = afr_pkg::PH_NONE;
      return;
    end
    case (rx_phase)
      afr_pkg::PH_HDR0: begin
        rx_sum = b;
        store_frame_byte(b);
        rx_phase = afr_pkg::PH_HDR1;
      end
      afr_pkg::PH_HDR1, afr_pkg::PH_HDR2, afr_pkg::PH_HDR3: begin
        rx_sum = rx_sum + b;
        store_frame_byte(b);
        rx_phase = afr_pkg::phase_t'(rx_phase + 3'd1);
      end
      afr_pkg::PH_COUNT: begin
        if (b >= DATA_LIMIT) begin
          rx_phase = afr_pkg::PH_NONE;   // count too large: abort
        end else begin
          rx_target = b[5:0];
          rx_seen   = '0;
          rx_sum    = rx_sum + b;
          store_frame_byte(b);
          // an empty frame goes straight to its checksum
          rx_phase  = (b != '0) ? afr_pkg::PH_DATA : afr_pkg::PH_CSUM;
        end
      end
      afr_pkg::PH_DATA: begin
        rx_seen = rx_seen + 6'd1;
        if (rx_seen >= DATA_LIMIT) begin
          rx_phase = afr_pkg::PH_NONE;
        end else begin
          rx_sum = rx_sum + b;
          store_frame_byte(b);
          if (rx_seen >= rx_target) rx_phase = afr_pkg::PH_CSUM;
        end
      end
      afr_pkg::PH_CSUM: begin
        store_frame_byte(b);
        rx_sum = rx_sum + b;
        if (rx_sum == '0) begin
          flen = (rx_count > FRAME_CAPACITY) ? FRAME_CAPACITY : int'(rx_count);
          for (int k = 0; k < flen; k++)
            expected_bytes.push_back('{rx_store[k], afr_pkg::LEN_W'(flen),
                                       (k + 1 == flen)});
          rx_seen = '0;
        end
        // good or bad, the line goes back to waiting for a start ID
        rx_phase = afr_pkg::PH_NONE;
        rx_idle  = 1'b1;
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  function automatic int draw_gap();
    int g;
    g = 0;
    if (!steady)
      while ($urandom_range(0, 99) < IDLE_PCT) g++;
    return g;
  endfunction

  // Offer one item and hold it until taken. Valid is left high on return so
  // that a back-to-back item needs no second assignment in the same step;
  // whoever stops sending lowers it.
  task automatic send_item(input logic cmd, input logic [afr_pkg::BYTE_W-1:0] b);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_framer(cmd, b);
  endtask

  // Drop valid, let every queued byte drain, then allow the block to finish
  // any item that produces nothing before touching the registers.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all five start IDs back to back with the write enable held high.
  task automatic load_addresses(input logic [afr_pkg::BYTE_W-1:0] own, motor, bcast,
                                remote, panel);
    logic [afr_pkg::NUM_REGS*afr_pkg::BYTE_W-1:0] ids;
    ids = {panel, remote, bcast, motor, own};
    for (int i = 0; i < afr_pkg::NUM_REGS; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= afr_pkg::REG_OWN + afr_pkg::REG_IDX_W'(i);
      cfg_data  <= ids[i*afr_pkg::BYTE_W +: afr_pkg::BYTE_W];
      start_ids[i] = ids[i*afr_pkg::BYTE_W +: afr_pkg::BYTE_W];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  // Send a complete frame: start ID, three header bytes, count, data and a
  // checksum that is either correct or deliberately spoiled.
  task automatic send_frame(input logic [afr_pkg::BYTE_W-1:0] start_id, input int count,
                            input bit good);
    logic [afr_pkg::BYTE_W-1:0] b;
    logic [afr_pkg::BYTE_W-1:0] sum;
    sum = start_id;
    send_item(afr_pkg::CMD_BYTE, start_id);
    // three header bytes, the count byte, then the data bytes
    for (int k = 0; k < 4 + count; k++) begin
      b = (k == 3) ? afr_pkg::BYTE_W'(count) : afr_pkg::BYTE_W'($urandom);
      sum = sum + b;
      send_item(afr_pkg::CMD_BYTE, b);
    end
    b = -sum;
    if (!good) b = b ^ afr_pkg::BYTE_W'($urandom_range(1, 255));
    send_item(afr_pkg::CMD_BYTE, b);
    frame_items += count + 6;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker and receiver stalls
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    frame_out_t exp_b;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected frame byte %02h (length %0d, last %0b)",
                   $time, frame_byte, frame_length, last);
        end else begin
          exp_b = expected_bytes.pop_front();
          if (frame_byte !== exp_b.data) begin
            mismatches++;
            $display("%0t: frame_byte expected %02h got %02h", $time, exp_b.data,
                     frame_byte);
          end
          if (frame_length !== exp_b.length) begin
            mismatches++;
            $display("%0t: frame_length expected %0d got %0d", $time, exp_b.length,
                     frame_length);
          end
          if (last !== exp_b.last) begin
            mismatches++;
            $display("%0t: last expected %0b got %0b", $time, exp_b.last, last);
          end
        end
      end
      out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Watchdog: give up well beyond the slowest legitimate run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Idle event on an idle line, then a byte that matches no address.
  task automatic test_stray_items();
    send_item(afr_pkg::CMD_IDLE, afr_pkg::BYTE_W'($urandom));
    send_item(afr_pkg::CMD_BYTE, 8'hFF);
  endtask

  // Smallest frame: count of zero, checksum follows the count directly.
  task automatic test_empty_frame();
    send_frame(8'h00, 0, 1'b1);
  endtask

  // A spoiled checksum drops the frame without a trace.
  task automatic test_bad_checksum();
    send_frame(8'h00, 1, 1'b0);
  endtask

  // Count over the limit aborts; a start ID is then ignored until the line
  // goes idle, after which framing resumes.
  task automatic test_count_abort();
    send_item(afr_pkg::CMD_BYTE, 8'h00);
    repeat (3) send_item(afr_pkg::CMD_BYTE, afr_pkg::BYTE_W'($urandom));
    send_item(afr_pkg::CMD_BYTE, 8'hFF);
    send_item(afr_pkg::CMD_BYTE, 8'h00);
    send_item(afr_pkg::CMD_IDLE, afr_pkg::BYTE_W'($urandom));
    send_frame(8'h00, 0, 1'b1);
  endtask

  // One spell of disorder: stray bytes, idle events, cut-off frames and
  // frames with an oversized count.
  task automatic send_noise();
    int n;
    case ($urandom_range(0, 3))
      0: send_item(afr_pkg::CMD_IDLE, afr_pkg::BYTE_W'($urandom));
      1: send_item(afr_pkg::CMD_BYTE, afr_pkg::BYTE_W'($urandom));
      2: begin
        // frame cut short; the line may or may not go idle afterwards
        send_item(afr_pkg::CMD_BYTE, start_ids[$urandom_range(0, afr_pkg::NUM_REGS - 1)]);
        n = $urandom_range(1, 8);
        repeat (n) send_item(afr_pkg::CMD_BYTE, afr_pkg::BYTE_W'($urandom));
        if ($urandom_range(0, 9) < 7)
          send_item(afr_pkg::CMD_IDLE, afr_pkg::BYTE_W'($urandom));
      end
      default: begin
        send_item(afr_pkg::CMD_BYTE, start_ids[$urandom_range(0, afr_pkg::NUM_REGS - 1)]);
        repeat (3) send_item(afr_pkg::CMD_BYTE, afr_pkg::BYTE_W'($urandom));
        send_item(afr_pkg::CMD_BYTE, afr_pkg::BYTE_W'($urandom_range(DATA_LIMIT, 255)));
        n = $urandom_range(0, 3);
        repeat (n) send_item(afr_pkg::CMD_BYTE, afr_pkg::BYTE_W'($urandom));
        send_item(afr_pkg::CMD_IDLE, afr_pkg::BYTE_W'($urandom));
      end
    endcase
  endtask

  // Mostly well-formed frames with random content, the rest disorder.
  task automatic test_random_traffic(input int quota);
    int target;
    int count;
    target = frame_items + quota;
    while (frame_items < target) begin
      if ($urandom_range(0, 99) < 75) begin
        if (!rx_idle) send_item(afr_pkg::CMD_IDLE, afr_pkg::BYTE_W'($urandom));
        count = ($urandom_range(0, 9) == 0) ? DATA_LIMIT - 1 : $urandom_range(0, 6);
        send_frame(start_ids[$urandom_range(0, afr_pkg::NUM_REGS - 1)], count,
                   $urandom_range(0, 99) < 85);
      end else begin
        send_noise();
      end
    end
  endtask

  initial begin
    for (int k = 0; k < afr_pkg::NUM_REGS; k++) start_ids[k] = '0;
    for (int k = 0; k < FRAME_CAPACITY; k++) rx_store[k] = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed checks, address registers still at reset
    test_stray_items();
    test_empty_frame();
    test_bad_checksum();
    test_count_abort();

    settle();
    load_addresses(8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF);
    test_random_traffic(45);

    // every address the same, no gaps and no stalls
    settle();
    load_addresses(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    steady = 1'b1;
    test_random_traffic(45);
    steady = 1'b0;

    settle();
    load_addresses(afr_pkg::BYTE_W'($urandom), afr_pkg::BYTE_W'($urandom),
                   afr_pkg::BYTE_W'($urandom), afr_pkg::BYTE_W'($urandom),
                   afr_pkg::BYTE_W'($urandom));
    test_random_traffic(45);

    settle();
    load_addresses(afr_pkg::BYTE_W'($urandom), afr_pkg::BYTE_W'($urandom),
                   afr_pkg::BYTE_W'($urandom), afr_pkg::BYTE_W'($urandom),
                   afr_pkg::BYTE_W'($urandom));
    test_random_traffic(45);

    // drain and allow the tail to clear
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
